[design/ile_pkg.sv]
// Shared types, field widths and command and result codes of the indexed list engine.
`timescale 1ns / 1ps
package ile_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;

  // The input tdata carries index and value, padded up to whole bytes.
  localparam int IN_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;

  localparam int CAPACITY_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PRINT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SUM    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ELEMENT       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY         = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUM           = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVED       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INDEX_ERROR   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DELETE_FAILED = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL          = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } ile_cmd_t;

endpackage

[design/ile_front.sv]
// Front end: accepts input items, drops unused command codes and queues the rest.
`timescale 1ns / 1ps
module ile_front
  import ile_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [5:0] index, [37:6] value, rest zero
  input  logic [CMD_W-1:0]      in_tuser,   // [2:0] cmd
  input  logic                  q_full,
  output logic                  q_push,
  output ile_cmd_t              q_entry
);

  logic legal;

  // Codes above sum cause no result, so they are taken and discarded here.
  assign legal     = (in_tuser == CMD_APPEND) || (in_tuser == CMD_INSERT) ||
                     (in_tuser == CMD_DELETE) || (in_tuser == CMD_PRINT) ||
                     (in_tuser == CMD_SUM);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && legal;

  always_comb begin
    q_entry.cmd   = in_tuser;
    q_entry.index = in_tdata[IDX_W-1:0];
    q_entry.value = in_tdata[IDX_W+DATA_W-1:IDX_W];
  end

endmodule

[design/ile_queue.sv]
// Short command queue between the front end and the list sequencer.
`timescale 1ns / 1ps
module ile_queue
  import ile_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ile_cmd_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output ile_cmd_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  ile_cmd_t        ent_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign full       = (fill_r == FW'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_entry = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("queue fill count above its depth");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && head_valid)) |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("queue fill count did not follow a lone push");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

[design/ile_back.sv]
// List sequencer: element memory, shift and walk control, and the result register.
`timescale 1ns / 1ps
module ile_back
  import ile_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ile_cmd_t           q_entry,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [DATA_W-1:0]  out_tdata,
  output logic [KIND_W-1:0]  out_tuser,
  output logic               out_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SHUP = 3'd1;
  localparam logic [2:0] ST_DRD  = 3'd2;
  localparam logic [2:0] ST_SHDN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_SUMW = 3'd5;
  localparam logic [2:0] ST_STAT = 3'd6;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic              pend_r, pend_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;

  logic              re, we;
  logic [AW-1:0]     ra, wa;
  logic [DATA_W-1:0] wd;
  logic              can_load, full;
  logic [XW-1:0]     idx_x, count_x;

  assign can_load = !out_valid_r || out_tready;
  assign full     = (count_r == CW'(CAPACITY));
  assign idx_x    = XW'(q_entry.index);
  assign count_x  = XW'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    wa_nxt        = wa_r;
    pend_nxt      = pend_r;
    val_nxt       = val_r;
    kind_nxt      = kind_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    re            = 1'b0;
    ra            = '0;
    we            = 1'b0;
    wa            = wa_r;
    wd            = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          val_nxt = '0;
          case (q_entry.cmd)
            CMD_APPEND: begin
              if (full) begin
                kind_nxt  = KIND_FULL;
                state_nxt = ST_STAT;
              end else begin
                pos_nxt   = count_r;
                ptr_nxt   = count_r;
                val_nxt   = q_entry.value;
                pend_nxt  = 1'b0;
                state_nxt = ST_SHUP;
              end
            end
            CMD_INSERT: begin
              if (idx_x > count_x) begin
                kind_nxt  = KIND_INDEX_ERROR;
                state_nxt = ST_STAT;
              end else if (full) begin
                kind_nxt  = KIND_FULL;
                state_nxt = ST_STAT;
              end else begin
                pos_nxt   = CW'(q_entry.index);
                ptr_nxt   = count_r;
                val_nxt   = q_entry.value;
                pend_nxt  = 1'b0;
                state_nxt = ST_SHUP;
              end
            end
            CMD_DELETE: begin
              if (idx_x >= count_x) begin
                kind_nxt  = KIND_DELETE_FAILED;
                state_nxt = ST_STAT;
              end else begin
                re        = 1'b1;
                ra        = AW'(q_entry.index);
                ptr_nxt   = CW'(q_entry.index) + CW'(1);
                pend_nxt  = 1'b0;
                state_nxt = ST_DRD;
              end
            end
            CMD_PRINT: begin
              if (count_r == '0) begin
                kind_nxt  = KIND_EMPTY;
                state_nxt = ST_STAT;
              end else begin
                ptr_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_EMIT;
              end
            end
            CMD_SUM: begin
              if (count_r == '0) begin
                kind_nxt  = KIND_EMPTY;
                state_nxt = ST_STAT;
              end else begin
                ptr_nxt   = '0;
                acc_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_SUMW;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Move entries pos..count-1 up by one, highest first: read one slot
      // down, write it back in the next cycle.
      ST_SHUP: begin
        if (pend_r) begin
          we = 1'b1;
        end
        if (ptr_r > pos_r) begin
          re       = 1'b1;
          ra       = AW'(ptr_r - CW'(1));
          wa_nxt   = AW'(ptr_r);
          ptr_nxt  = ptr_r - CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            we        = 1'b1;
            wa        = AW'(pos_r);
            wd        = val_r;
            count_nxt = count_r + CW'(1);
            ptr_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_DRD: begin
        val_nxt   = rd_data_r;
        state_nxt = ST_SHDN;
      end

      // Close the gap left by the removed entry, lowest first.
      ST_SHDN: begin
        if (pend_r) begin
          we = 1'b1;
        end
        if (ptr_r < count_r) begin
          re       = 1'b1;
          ra       = AW'(ptr_r);
          wa_nxt   = AW'(ptr_r - CW'(1));
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CW'(1);
            kind_nxt  = KIND_REMOVED;
            state_nxt = ST_STAT;
          end
        end
      end

      // One read is kept in flight; the held read data waits out a stall.
      ST_EMIT: begin
        if (pend_r && can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          out_kind_nxt  = KIND_ELEMENT;
          out_last_nxt  = (ptr_r == count_r);
          if (ptr_r == count_r) begin
            state_nxt = ST_IDLE;
          end
        end
        if ((ptr_r < count_r) && (!pend_r || can_load)) begin
          re       = 1'b1;
          ra       = AW'(ptr_r);
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = pend_r && !can_load;
        end
      end

      ST_SUMW: begin
        if (pend_r) begin
          acc_nxt = acc_r + rd_data_r;
        end
        if (ptr_r < count_r) begin
          re       = 1'b1;
          ra       = AW'(ptr_r);
          ptr_nxt  = ptr_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            kind_nxt  = KIND_SUM;
            val_nxt   = acc_r;
            state_nxt = ST_STAT;
          end
        end
      end

      ST_STAT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = val_r;
          out_kind_nxt  = kind_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    pos_r      <= pos_nxt;
    wa_r       <= wa_nxt;
    val_r      <= val_nxt;
    kind_r     <= kind_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1))))
    else $error("element count moved by more than one");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("command taken while the sequencer was busy");
  a_shup_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHUP) |-> ((ptr_r >= pos_r) && (ptr_r <= count_r)))
    else $error("insert shift pointer out of range");
  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((state_r == ST_SHUP) || (state_r == ST_SHDN) ||
                (state_r == ST_EMIT) || (state_r == ST_SUMW) || (state_r == ST_IDLE)))
    else $error("read in flight outside a walk");
`endif

endmodule

[design/indexed_list_engine_top.sv]
// Top level of the indexed list engine: front end, command queue and list sequencer.
//
//  Channel  Direction  Carries
//  in_*     input      tuser: cmd; tdata: index, value
//  out_*    output     tuser: kind; tdata: result_value; tlast: last
//
// Print and sum walk the element memory through its single read port, one entry a cycle
// while the result output is not stalled. Insert shifts the entries from its position up
// before it echoes the whole list, append shifts none; delete shifts the entries above
// the index down before it reports the removed value. Reset clears the count, the queue
// and the result register; the memory is not cleared. A stalled result holds the walk
// while the queue keeps taking items until it is full.
`timescale 1ns / 1ps
module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [5:0] index, [37:6] value, [39:38] zero
  input  logic [CMD_W-1:0]      in_tuser,   // [2:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [31:0] result_value
  output logic [KIND_W-1:0]     out_tuser,  // [2:0] kind
  output logic                  out_tlast
);

  logic     q_full, q_push, q_valid, q_pop;
  ile_cmd_t push_entry, head_entry;

  ile_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  ile_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  ile_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the indexed list engine: directed and random command streams.
`timescale 1ns / 1ps
module testbench;
  import ile_pkg::*;

  localparam int LIST_CAPACITY = CAPACITY_DEF;
  // Command codes that the block must ignore without producing a result.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 3'd7;
  localparam logic [IDX_W-1:0] IDX_TOP          = '1;
  localparam logic [DATA_W-1:0] VALUE_MIN       = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VALUE_MAX       = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic              last;
  } list_result_t;

  // Holds a shadow copy of the list and the results that the block still owes.
  class list_scoreboard;
    logic [DATA_W-1:0] shadow_list[$];
    list_result_t      pending_results[$];
    int                errors;

    function int length();
      return shadow_list.size();
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void push_result(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value, logic last);
      list_result_t r;
      r.kind  = kind;
      r.value = value;
      r.last  = last;
      pending_results.push_back(r);
    endfunction

    function void push_list();
      if (shadow_list.size() == 0) begin
        push_result(KIND_EMPTY, '0, 1'b1);
      end else begin
        foreach (shadow_list[i])
          push_result(KIND_ELEMENT, shadow_list[i], i == shadow_list.size() - 1);
      end
    endfunction

    function void add_element(int pos, logic [DATA_W-1:0] value);
      if (shadow_list.size() >= LIST_CAPACITY) begin
        push_result(KIND_FULL, '0, 1'b1);
      end else begin
        shadow_list.insert(pos, value);
        push_list();
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                               logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] total;
      case (cmd)
        CMD_APPEND: add_element(shadow_list.size(), value);
        CMD_INSERT: begin
          // The position check takes precedence over the full check.
          if (idx > shadow_list.size()) push_result(KIND_INDEX_ERROR, '0, 1'b1);
          else add_element(idx, value);
        end
        CMD_DELETE: begin
          if (idx >= shadow_list.size()) begin
            push_result(KIND_DELETE_FAILED, '0, 1'b1);
          end else begin
            push_result(KIND_REMOVED, shadow_list[idx], 1'b1);
            shadow_list.delete(idx);
          end
        end
        CMD_PRINT: push_list();
        CMD_SUM: begin
          if (shadow_list.size() == 0) begin
            push_result(KIND_EMPTY, '0, 1'b1);
          end else begin
            total = '0;
            foreach (shadow_list[i]) total += shadow_list[i];
            push_result(KIND_SUM, total, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] value, logic last);
      list_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, kind %0d value %h last %b",
                 $time, kind, value, last);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (kind !== exp.kind) begin
        $display("%0t: kind mismatch, expected %0d, got %0d", $time, exp.kind, kind);
        errors++;
      end
      if (value !== exp.value) begin
        $display("%0t: value mismatch, expected %h, got %h", $time, exp.value, value);
        errors++;
      end
      if (last !== exp.last) begin
        $display("%0t: last mismatch, expected %b, got %b", $time, exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  list_scoreboard board;
  int             tx_quiet;
  int             rx_quiet;

  indexed_list_engine_top #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly random waits, broken up now and then by a stretch of back-to-back items.
  function automatic int draw_wait(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] value);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'({value, idx});
    do @(posedge clk); while (!in_tready);
    board.note_command(cmd, idx, value);
  endtask

  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic random_item(input int add_pct, input int del_pct);
    int               r;
    int               n;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    n = board.length();
    if ($urandom_range(0, 24) == 0)
      send_command(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)),
                   IDX_W'($urandom), $urandom);
    if (r < add_pct) begin
      if ($urandom_range(0, 7) == 0) idx = IDX_W'($urandom_range(0, IDX_TOP));
      else idx = IDX_W'($urandom_range(0, n));
      send_command($urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND, idx, $urandom);
    end else if (r < add_pct + del_pct) begin
      if (n == 0 || $urandom_range(0, 7) == 0) idx = IDX_W'($urandom_range(0, IDX_TOP));
      else idx = IDX_W'($urandom_range(0, n - 1));
      send_command(CMD_DELETE, idx, $urandom);
    end else begin
      send_command($urandom_range(0, 1) ? CMD_PRINT : CMD_SUM, IDX_W'($urandom), $urandom);
    end
  endtask

  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(rx_quiet);
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  initial begin
    board      = new();
    tx_quiet   = 0;
    rx_quiet   = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_APPEND;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Every status path on an empty list, and the ignored command codes.
    send_command(CMD_PRINT, '0, '0);
    send_command(CMD_SUM, '0, '0);
    send_command(CMD_DELETE, '0, '0);
    send_command(CMD_INSERT, 6'd1, 32'd5);
    send_command(CMD_INSERT, IDX_TOP, '1);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_CODE; c++)
      send_command(CMD_W'(c), IDX_TOP, '1);

    // Build a short list from the value extremes; the sum wraps.
    send_command(CMD_INSERT, '0, VALUE_MIN);
    send_command(CMD_APPEND, IDX_TOP, VALUE_MAX);
    send_command(CMD_APPEND, '0, VALUE_MAX);
    send_command(CMD_APPEND, '0, '1);
    send_command(CMD_INSERT, 6'd2, 32'd1234);
    send_command(CMD_INSERT, 6'd5, '0);
    send_command(CMD_PRINT, '0, '0);
    send_command(CMD_SUM, '0, '0);

    // Delete beyond the end, then from the head, the tail and the middle.
    send_command(CMD_DELETE, 6'd6, '0);
    send_command(CMD_DELETE, IDX_TOP, '0);
    send_command(CMD_DELETE, '0, '0);
    send_command(CMD_DELETE, 6'd4, '0);
    send_command(CMD_DELETE, 6'd1, '0);
    send_command(CMD_INSERT, IDX_TOP, 32'd7);
    send_command(CMD_SUM, '0, '0);
    drain_results();

    // Grow to capacity, then try every add on a full list.
    while (board.length() < LIST_CAPACITY) random_item(90, 5);
    send_command(CMD_APPEND, '0, $urandom);
    send_command(CMD_INSERT, IDX_W'(LIST_CAPACITY), $urandom);
    send_command(CMD_INSERT, IDX_W'(LIST_CAPACITY + 1), $urandom);
    send_command(CMD_INSERT, '0, $urandom);
    send_command(CMD_PRINT, '0, '0);
    send_command(CMD_SUM, '0, '0);
    drain_results();

    while (board.length() > 0) random_item(5, 90);
    repeat (10) random_item(40, 35);

    drain_results();
    repeat (2 * LIST_CAPACITY + 20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
design/ile_pkg.sv
design/ile_front.sv
design/ile_queue.sv
design/ile_back.sv
design/indexed_list_engine_top.sv
sim/testbench.sv
